// File: rtl/bext_pkg.sv
// shared types and constants for the border extension offset table core
// no dependencies; every other file refers to it by scoped names
package bext_pkg;

   localparam int unsigned LEN_W     = 16;
   localparam int unsigned STRIDE_W  = 16;
   localparam int unsigned WIN_W     = 8;
   localparam int unsigned ROW_W     = 8;
   localparam int unsigned MODE_W    = 3;
   localparam int unsigned POS_W     = 17;
   localparam int unsigned COORD_W   = 19;
   localparam int unsigned MOD_W     = 17;
   localparam int unsigned MOD_STEPS = 9;
   localparam int unsigned OFF_W     = 33;
   localparam int unsigned OP_W      = 20;
   localparam int unsigned CSR_IDX_W = 2;
   localparam int unsigned CSR_DAT_W = 16;

   localparam logic [CSR_IDX_W-1:0] CSR_AXIS_LENGTH = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_AXIS_STRIDE = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_WINDOW_SIZE = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_EXTEND_MODE = 2'd3;

   typedef enum logic [MODE_W-1:0] {
      EXT_CONSTANT  = 3'd0,
      EXT_EDGE      = 3'd1,
      EXT_WRAP      = 3'd2,
      EXT_SYMMETRIC = 3'd3,
      EXT_REFLECT   = 3'd4
   } ext_mode_type;

   // effective configuration: length already masked and forced nonzero,
   // window already clamped
   typedef struct packed {
      logic [LEN_W-1:0]    length;
      logic [STRIDE_W-1:0] stride;
      logic [WIN_W-1:0]    window;
      logic [MODE_W-1:0]   mode;
   } cfg_type;

   typedef struct packed {
      logic                       neg;
      logic                       in_range;
      logic signed [COORD_W-1:0]  coord;
      logic [POS_W-1:0]           pos;
      logic [MOD_W-1:0]           period;
      logic [MOD_W-1:0]           rem;
   } lane_type;

endpackage

// File: rtl/bext_csr.sv
// configuration registers with the length mask and window clamp applied
// depends on bext_pkg
module bext_csr #(
   parameter int unsigned MAX_WINDOW  = 255,
   parameter int unsigned LENGTH_BITS = 16
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [bext_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [bext_pkg::CSR_DAT_W-1:0]  csr_data,
   output bext_pkg::cfg_type               cfg
);

   localparam int unsigned LW = (LENGTH_BITS < bext_pkg::LEN_W) ? LENGTH_BITS : bext_pkg::LEN_W;

   logic [LW-1:0]                     length_ff, length_in;
   logic [bext_pkg::STRIDE_W-1:0]     stride_ff, stride_in;
   logic [bext_pkg::WIN_W-1:0]        window_ff, window_in;
   logic [bext_pkg::MODE_W-1:0]       mode_ff, mode_in;
   logic                              wr;

   assign csr_ready = 1'b1;
   assign wr        = csr_valid & csr_ready;

   always_comb begin
      length_in = length_ff;
      stride_in = stride_ff;
      window_in = window_ff;
      mode_in   = mode_ff;
      if (wr) begin
         case (csr_index)
            bext_pkg::CSR_AXIS_LENGTH: length_in = csr_data[LW-1:0];
            bext_pkg::CSR_AXIS_STRIDE: stride_in = csr_data[bext_pkg::STRIDE_W-1:0];
            bext_pkg::CSR_WINDOW_SIZE: window_in = csr_data[bext_pkg::WIN_W-1:0];
            bext_pkg::CSR_EXTEND_MODE: mode_in   = csr_data[bext_pkg::MODE_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         length_ff <= LW'(1);
         stride_ff <= bext_pkg::STRIDE_W'(1);
         window_ff <= bext_pkg::WIN_W'(5);
         mode_ff   <= bext_pkg::MODE_W'(bext_pkg::EXT_CONSTANT);
      end else begin
         length_ff <= length_in;
         stride_ff <= stride_in;
         window_ff <= window_in;
         mode_ff   <= mode_in;
      end
   end

   always_comb begin
      cfg.length = (length_ff == '0) ? bext_pkg::LEN_W'(1) : bext_pkg::LEN_W'(length_ff);
      cfg.stride = stride_ff;
      cfg.window = (window_ff > bext_pkg::WIN_W'(MAX_WINDOW)) ?
                   bext_pkg::WIN_W'(MAX_WINDOW) : window_ff;
      cfg.mode   = mode_ff;
   end

endmodule

// File: rtl/bext_front.sv
// front stages: window position, tap coordinate, period and first reduction
// depends on bext_pkg
module bext_front (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          in_valid,
   input  logic [bext_pkg::ROW_W-1:0]    in_row,
   input  logic [bext_pkg::ROW_W-1:0]    in_tap,
   input  bext_pkg::cfg_type             cfg,
   output logic                          out_valid,
   output bext_pkg::lane_type            out_lane
);

   logic                                 v1_ff, v2_ff, v3_ff;
   logic [bext_pkg::ROW_W-1:0]           row_ff, tap_ff;
   logic [bext_pkg::WIN_W-2:0]           centre;
   logic [bext_pkg::POS_W-1:0]           pos_in, pos_ff;
   logic signed [bext_pkg::COORD_W-1:0]  coord_in, coord_ff;
   logic [bext_pkg::MOD_W-1:0]           period, mag;
   bext_pkg::lane_type                   lane_in, lane_ff;

   // stage 1: capture the transaction
   always_ff @(posedge clock) begin
      if (reset) v1_ff <= 1'b0;
      else       v1_ff <= in_valid;
      row_ff <= in_row;
      tap_ff <= in_tap;
   end

   // rows past the centre jump to the high edge when the axis fits the window
   always_comb begin
      centre = cfg.window[bext_pkg::WIN_W-1:1];
      if ((row_ff > {1'b0, centre}) && (cfg.length >= bext_pkg::LEN_W'(cfg.window)))
         pos_in = bext_pkg::POS_W'(cfg.length) - bext_pkg::POS_W'(cfg.window)
                + bext_pkg::POS_W'(row_ff);
      else
         pos_in = bext_pkg::POS_W'(row_ff);
      coord_in = $signed({11'b0, tap_ff}) - $signed({12'b0, centre})
               + $signed({2'b0, pos_in});
   end

   // stage 2
   always_ff @(posedge clock) begin
      if (reset) v2_ff <= 1'b0;
      else       v2_ff <= v1_ff;
      pos_ff   <= pos_in;
      coord_ff <= coord_in;
   end

   always_comb begin
      case (cfg.mode)
         bext_pkg::EXT_SYMMETRIC: period = {cfg.length, 1'b0};
         bext_pkg::EXT_REFLECT:   period = {cfg.length, 1'b0} - bext_pkg::MOD_W'(2);
         default:                 period = {1'b0, cfg.length};
      endcase
      lane_in.neg      = coord_ff[bext_pkg::COORD_W-1];
      lane_in.in_range = !coord_ff[bext_pkg::COORD_W-1]
                         && (coord_ff < $signed({3'b0, cfg.length}));
      lane_in.coord    = coord_ff;
      lane_in.pos      = pos_ff;
      lane_in.period   = period;
      mag = coord_ff[bext_pkg::COORD_W-1] ? bext_pkg::MOD_W'(-coord_ff)
                                          : coord_ff[bext_pkg::MOD_W-1:0];
      // a positive coordinate exceeds the period by at most a few hundred
      if (!coord_ff[bext_pkg::COORD_W-1] && (mag >= period))
         lane_in.rem = mag - period;
      else
         lane_in.rem = mag;
   end

   // stage 3
   always_ff @(posedge clock) begin
      if (reset) v3_ff <= 1'b0;
      else       v3_ff <= v2_ff;
      lane_ff <= lane_in;
   end

   assign out_valid = v3_ff;
   assign out_lane  = lane_ff;

endmodule

// File: rtl/bext_mod_step.sv
// one restoring step of the remainder unit: subtract period << SHIFT if it fits
// depends on bext_pkg
module bext_mod_step #(
   parameter int unsigned SHIFT = 0
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   input  bext_pkg::lane_type  in_lane,
   output logic                out_valid,
   output bext_pkg::lane_type  out_lane
);

   localparam int unsigned WIDE_W = bext_pkg::MOD_W + bext_pkg::MOD_STEPS - 1;

   logic [WIDE_W-1:0]   shifted;
   logic                valid_ff;
   bext_pkg::lane_type  lane_in, lane_ff;

   always_comb begin
      shifted = WIDE_W'(in_lane.period) << SHIFT;
      lane_in = in_lane;
      if (WIDE_W'(in_lane.rem) >= shifted)
         lane_in.rem = in_lane.rem - shifted[bext_pkg::MOD_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) valid_ff <= 1'b0;
      else       valid_ff <= in_valid;
      lane_ff <= lane_in;
   end

   assign out_valid = valid_ff;
   assign out_lane  = lane_ff;

endmodule

// File: rtl/bext_back.sv
// back stages: mode fold, offset from the window position, stride multiply
// depends on bext_pkg
module bext_back (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                in_valid,
   input  bext_pkg::lane_type                  in_lane,
   input  bext_pkg::cfg_type                   cfg,
   output logic                                out_valid,
   output logic signed [bext_pkg::OFF_W-1:0]   out_offset,
   output logic                                out_fill
);

   logic [bext_pkg::MOD_W-1:0]            rr;
   logic signed [bext_pkg::COORD_W-1:0]   folded, diff;
   logic                                  fill_in, fill1_ff, fill2_ff;
   logic signed [bext_pkg::OP_W-1:0]      op_in, op_ff;
   logic                                  v1_ff, v2_ff;
   logic signed [bext_pkg::STRIDE_W:0]    stride_s;
   logic signed [bext_pkg::OP_W+bext_pkg::STRIDE_W:0] prod;
   logic signed [bext_pkg::OFF_W-1:0]     offset_ff;

   always_comb begin
      // negative coordinates were reduced by magnitude
      rr = (in_lane.neg && (in_lane.rem != '0)) ? in_lane.period - in_lane.rem
                                                : in_lane.rem;
      fill_in = 1'b0;
      folded = '0;
      case (cfg.mode)
         bext_pkg::EXT_CONSTANT: begin
            fill_in = 1'b1;
            folded  = '0;
         end
         bext_pkg::EXT_EDGE:
            folded = in_lane.neg ? '0 : $signed({3'b0, cfg.length}) - 19'sd1;
         bext_pkg::EXT_WRAP:
            folded = $signed({2'b0, rr});
         bext_pkg::EXT_SYMMETRIC:
            folded = (rr >= bext_pkg::MOD_W'(cfg.length)) ?
                     $signed({2'b0, in_lane.period - rr - bext_pkg::MOD_W'(1)}) :
                     $signed({2'b0, rr});
         bext_pkg::EXT_REFLECT:
            if (cfg.length == bext_pkg::LEN_W'(1))
               folded = '0;
            else if (rr >= bext_pkg::MOD_W'(cfg.length))
               folded = $signed({2'b0, in_lane.period - rr});
            else
               folded = $signed({2'b0, rr});
         default:
            folded = -19'sd1;
      endcase
      if (in_lane.in_range) begin
         folded  = in_lane.coord;
         fill_in = 1'b0;
      end
      diff  = folded - $signed({2'b0, in_lane.pos});
      op_in = fill_in ? $signed({4'b0, cfg.length}) : bext_pkg::OP_W'(diff);
   end

   always_ff @(posedge clock) begin
      if (reset) v1_ff <= 1'b0;
      else       v1_ff <= in_valid;
      op_ff    <= op_in;
      fill1_ff <= fill_in;
   end

   assign stride_s = $signed({1'b0, cfg.stride});
   assign prod     = op_ff * stride_s;

   always_ff @(posedge clock) begin
      if (reset) v2_ff <= 1'b0;
      else       v2_ff <= v1_ff;
      offset_ff <= prod[bext_pkg::OFF_W-1:0];
      fill2_ff  <= fill1_ff;
   end

   assign out_valid  = v2_ff;
   assign out_offset = offset_ff;
   assign out_fill   = fill2_ff;

endmodule

// File: rtl/border_extension_offset_table_core.sv
// Window offset table entry generator with border extension (constant, edge,
// wrap, symmetric, reflect). A transaction is taken on every cycle that start
// is high; busy is always low. Each result appears on rsp_offset/rsp_is_fill
// with rsp_valid high for one cycle, in order, one per cycle; the receiver
// cannot stall, so results must be taken when shown. Each transaction passes
// three front stages, the nine-stage remainder pipeline used by the wrap,
// symmetric and reflect modes and two back stages, 14 register stages in all.
// Configuration writes are always ready and take effect once registered;
// write them only while no transaction is in flight.
module border_extension_offset_table_core #(
   parameter int unsigned MAX_WINDOW  = 255,
   parameter int unsigned LENGTH_BITS = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic [bext_pkg::ROW_W-1:0]          req_row,
   input  logic [bext_pkg::ROW_W-1:0]          req_tap,
   output logic                                rsp_valid,
   output logic signed [bext_pkg::OFF_W-1:0]   rsp_offset,
   output logic                                rsp_is_fill,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [bext_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [bext_pkg::CSR_DAT_W-1:0]      csr_data
);

   bext_pkg::cfg_type   cfg;
   logic                accept;
   logic                lane_valid [0:bext_pkg::MOD_STEPS];
   bext_pkg::lane_type  lane       [0:bext_pkg::MOD_STEPS];

   assign busy   = 1'b0;
   assign accept = start & ~busy;

   bext_csr #(
      .MAX_WINDOW  (MAX_WINDOW),
      .LENGTH_BITS (LENGTH_BITS)
   ) u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   bext_front u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (accept),
      .in_row    (req_row),
      .in_tap    (req_tap),
      .cfg       (cfg),
      .out_valid (lane_valid[0]),
      .out_lane  (lane[0])
   );

   // most significant quotient bit first
   for (genvar k = 0; k < bext_pkg::MOD_STEPS; k++) begin : g_mod
      bext_mod_step #(
         .SHIFT (bext_pkg::MOD_STEPS - 1 - k)
      ) u_step (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (lane_valid[k]),
         .in_lane   (lane[k]),
         .out_valid (lane_valid[k+1]),
         .out_lane  (lane[k+1])
      );
   end

   bext_back u_back (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (lane_valid[bext_pkg::MOD_STEPS]),
      .in_lane    (lane[bext_pkg::MOD_STEPS]),
      .cfg        (cfg),
      .out_valid  (rsp_valid),
      .out_offset (rsp_offset),
      .out_fill   (rsp_is_fill)
   );

endmodule
